@@ rtl/rne_pkg.sv @@
`timescale 1ns / 1ps

package rne_pkg;

    localparam int VALUE_LIMIT = 4000;
    localparam int REM_W       = 12;
    localparam int TBL_DEPTH   = 13;
    localparam int IDX_W       = 4;

    localparam logic [6:0] SYM_NONE = 7'h00;
    localparam logic [6:0] SYM_I    = 7'h49;
    localparam logic [6:0] SYM_V    = 7'h56;
    localparam logic [6:0] SYM_X    = 7'h58;
    localparam logic [6:0] SYM_L    = 7'h4C;
    localparam logic [6:0] SYM_C    = 7'h43;
    localparam logic [6:0] SYM_D    = 7'h44;
    localparam logic [6:0] SYM_M    = 7'h4D;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_RUN
    } state_t;

    typedef struct packed {
        logic [REM_W-1:0] weight;
        logic [6:0]       first;
        logic [6:0]       second;
        logic             pair;
    } tbl_entry_t;

    // greedy weights, largest first, subtractive pairs included
    function automatic tbl_entry_t tbl_lookup(input logic [IDX_W-1:0] idx);
        tbl_entry_t e;
        case (idx)
            4'd0:    e = '{12'd1000, SYM_M, SYM_NONE, 1'b0};
            4'd1:    e = '{12'd900,  SYM_C, SYM_M,    1'b1};
            4'd2:    e = '{12'd500,  SYM_D, SYM_NONE, 1'b0};
            4'd3:    e = '{12'd400,  SYM_C, SYM_D,    1'b1};
            4'd4:    e = '{12'd100,  SYM_C, SYM_NONE, 1'b0};
            4'd5:    e = '{12'd90,   SYM_X, SYM_C,    1'b1};
            4'd6:    e = '{12'd50,   SYM_L, SYM_NONE, 1'b0};
            4'd7:    e = '{12'd40,   SYM_X, SYM_L,    1'b1};
            4'd8:    e = '{12'd10,   SYM_X, SYM_NONE, 1'b0};
            4'd9:    e = '{12'd9,    SYM_I, SYM_X,    1'b1};
            4'd10:   e = '{12'd5,    SYM_V, SYM_NONE, 1'b0};
            4'd11:   e = '{12'd4,    SYM_I, SYM_V,    1'b1};
            default: e = '{12'd1,    SYM_I, SYM_NONE, 1'b0};
        endcase
        return e;
    endfunction

endpackage

@@ rtl/roman_numeral_encoder.sv @@
`timescale 1ns / 1ps

// channel   signals                        payload
// request   in_valid / in_ready            value (16 bit signed)
// result    out_valid / out_ready          symbol (7), invalid, last
//
// a request is accepted, then each step emits one character or skips one table
// weight (at most 12 skipped), until the last character is emitted
// the shared compare and subtract unit walks the 13 entry weight table
// an out of range request gives one result
// a stalled result register holds back the next character; rst_n clears control state

module roman_numeral_encoder
    import rne_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [6:0]         symbol,
    output logic               invalid,
    output logic               last
);

    state_t state_reg, state_next;

    logic [REM_W-1:0] rem_reg, rem_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             half_reg, half_next;
    logic             inv_reg, inv_next;

    logic             out_valid_reg, out_valid_next;
    logic [6:0]       symbol_reg, symbol_next;
    logic             invalid_reg, invalid_next;
    logic             last_reg, last_next;

    tbl_entry_t       ent;
    logic [REM_W-1:0] diff;
    logic             ge;
    logic             slot_free;
    logic             accept;
    logic             in_range;
    logic             emit;
    logic             emit_last;
    logic [6:0]       emit_sym;
    logic             done;

    assign accept    = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;
    assign in_range  = !value[15] && (value != 16'sd0)
                       && (value[14:0] < 15'(VALUE_LIMIT));

    // shared compare and subtract
    assign ent  = tbl_lookup(idx_reg);
    assign ge   = rem_reg >= ent.weight;
    assign diff = rem_reg - ent.weight;

    // sequencer step
    always_comb
    begin
        emit      = 1'b0;
        emit_last = 1'b0;
        emit_sym  = SYM_NONE;
        done      = 1'b0;
        rem_next  = rem_reg;
        idx_next  = idx_reg;
        half_next = half_reg;
        inv_next  = inv_reg;
        if (state_reg == ST_IDLE)
        begin
            if (accept)
            begin
                rem_next  = value[REM_W-1:0];
                idx_next  = '0;
                half_next = 1'b0;
                inv_next  = !in_range;
            end
        end
        else if (inv_reg)
        begin
            if (slot_free)
            begin
                emit      = 1'b1;
                emit_last = 1'b1;
                done      = 1'b1;
            end
        end
        else if (half_reg)
        begin
            if (slot_free)
            begin
                emit      = 1'b1;
                emit_sym  = ent.second;
                emit_last = (rem_reg == '0);
                done      = emit_last;
                half_next = 1'b0;
            end
        end
        else if (ge)
        begin
            if (slot_free)
            begin
                emit      = 1'b1;
                emit_sym  = ent.first;
                rem_next  = diff;
                half_next = ent.pair;
                emit_last = !ent.pair && (diff == '0);
                done      = emit_last;
            end
        end
        else
        begin
            idx_next = idx_reg + 1'b1;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE: in_ready = 1'b1;
            ST_RUN:  in_ready = 1'b0;
            default: in_ready = 1'b0;
        endcase
    end

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        symbol_next    = symbol_reg;
        invalid_next   = invalid_reg;
        last_next      = last_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            symbol_next    = emit_sym;
            invalid_next   = inv_reg;
            last_next      = emit_last;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            half_reg      <= 1'b0;
            inv_reg       <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            half_reg      <= half_next;
            inv_reg       <= inv_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        symbol_reg  <= symbol_next;
        invalid_reg <= invalid_next;
        last_reg    <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign symbol    = symbol_reg;
    assign invalid   = invalid_reg;
    assign last      = last_reg;

    a_invalid_alone: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && invalid |-> last && (symbol == SYM_NONE))
        else $error("invalid result not a lone last result");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready)
        else $error("request taken while previous still in work");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) && !inv_reg |-> rem_reg < REM_W'(VALUE_LIMIT))
        else $error("remainder out of range");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        emit && emit_last |=> (state_reg == ST_IDLE))
        else $error("sequencer busy after last character");

endmodule
